// ----- rtl/core/rfc_pkg.sv -----
// Rail fence cipher package: sizes, microcode control word and status types.
// Used by every module of the rail fence cipher block; depends on nothing.
package rfc_pkg;

    localparam int MAX_LEN = 64;
    localparam int ADDR_W  = $clog2(MAX_LEN);
    localparam int LEN_W   = ADDR_W + 1;
    localparam int BYTE_W  = 8;
    localparam int RAILS_W = 7;
    localparam int SPAN_W  = RAILS_W + 1;
    localparam int SUM_W   = (SPAN_W > LEN_W) ? SPAN_W + 1 : LEN_W + 1;
    localparam int CFG_W   = 7;
    localparam int CIDX_W  = 1;

    localparam logic [CIDX_W-1:0]  REG_DIRECTION = 1'b0;
    localparam logic [CIDX_W-1:0]  REG_RAILS     = 1'b1;
    localparam logic [RAILS_W-1:0] RAILS_RESET   = 7'd2;

    typedef enum logic [1:0] {
        COND_ALWAYS   = 2'd0,
        COND_IN_LAST  = 2'd1,
        COND_GEN_END  = 2'd2,
        COND_EMIT_END = 2'd3
    } cond_t;

    localparam int UPC_W = 3;
    typedef logic [UPC_W-1:0] upc_t;

    localparam upc_t UPC_LOAD    = 3'd0;
    localparam upc_t UPC_SETUP   = 3'd1;
    localparam upc_t UPC_PERM    = 3'd2;
    localparam upc_t UPC_DRAIN   = 3'd3;
    localparam upc_t UPC_EMIT_RD = 3'd4;
    localparam upc_t UPC_EMIT    = 3'd5;

    typedef struct packed {
        logic  load_en;
        logic  setup_en;
        logic  perm_en;
        logic  emrd_en;
        logic  emit_en;
        cond_t cond;
        upc_t  target;
    } ctrl_t;

    typedef struct packed {
        logic in_last_acc;
        logic gen_end;
        logic emit_end;
    } stat_t;

endpackage

// ----- rtl/core/rfc_ucode_rom.sv -----
// Rail fence cipher control store: one control word per program step.
// Depends on rfc_pkg.
module rfc_ucode_rom (
    input  rfc_pkg::upc_t  upc,
    output rfc_pkg::ctrl_t word
);

    always_comb
    begin
        word = '0;
        unique case (upc)
            rfc_pkg::UPC_LOAD:
            begin
                word.load_en = 1'b1;
                word.cond    = rfc_pkg::COND_IN_LAST;
                word.target  = rfc_pkg::UPC_SETUP;
            end
            rfc_pkg::UPC_SETUP:
            begin
                word.setup_en = 1'b1;
                word.cond     = rfc_pkg::COND_ALWAYS;
                word.target   = rfc_pkg::UPC_PERM;
            end
            rfc_pkg::UPC_PERM:
            begin
                word.perm_en = 1'b1;
                word.cond    = rfc_pkg::COND_GEN_END;
                word.target  = rfc_pkg::UPC_DRAIN;
            end
            rfc_pkg::UPC_DRAIN:
            begin
                word.cond   = rfc_pkg::COND_ALWAYS;
                word.target = rfc_pkg::UPC_EMIT_RD;
            end
            rfc_pkg::UPC_EMIT_RD:
            begin
                word.emrd_en = 1'b1;
                word.cond    = rfc_pkg::COND_ALWAYS;
                word.target  = rfc_pkg::UPC_EMIT;
            end
            rfc_pkg::UPC_EMIT:
            begin
                word.emit_en = 1'b1;
                word.cond    = rfc_pkg::COND_EMIT_END;
                word.target  = rfc_pkg::UPC_LOAD;
            end
            default:
            begin
                word.cond   = rfc_pkg::COND_ALWAYS;
                word.target = rfc_pkg::UPC_LOAD;
            end
        endcase
    end

endmodule

// ----- rtl/core/rfc_seq.sv -----
// Rail fence cipher sequencer: step counter with conditional jumps.
// Depends on rfc_pkg and rfc_ucode_rom.
module rfc_seq (
    input  logic           clk,
    input  logic           rst_n,
    input  rfc_pkg::stat_t stat,
    output rfc_pkg::ctrl_t ctrl
);

    rfc_pkg::upc_t upc_reg;
    rfc_pkg::upc_t upc_next;
    logic          take;

    rfc_ucode_rom u_rom (
        .upc  (upc_reg),
        .word (ctrl)
    );

    always_comb
    begin
        unique case (ctrl.cond)
            rfc_pkg::COND_ALWAYS:   take = 1'b1;
            rfc_pkg::COND_IN_LAST:  take = stat.in_last_acc;
            rfc_pkg::COND_GEN_END:  take = stat.gen_end;
            rfc_pkg::COND_EMIT_END: take = stat.emit_end;
            default:                take = 1'b1;
        endcase
        upc_next = take ? ctrl.target : upc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= rfc_pkg::UPC_LOAD;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ----- rtl/core/rfc_datapath.sv -----
// Rail fence cipher datapath: message store, zigzag address walker, result store
// and output register, driven by the sequencer's control word. Depends on rfc_pkg.
module rfc_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  rfc_pkg::ctrl_t               ctrl,
    output rfc_pkg::stat_t               stat,
    input  logic                         cfg_wr_en,
    input  logic [rfc_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [rfc_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [rfc_pkg::BYTE_W-1:0]   data_byte,
    input  logic                         last_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [rfc_pkg::BYTE_W-1:0]   out_byte,
    output logic                         out_last,
    output logic                         truncated
);

    logic [rfc_pkg::BYTE_W-1:0] store_mem [rfc_pkg::MAX_LEN];
    logic [rfc_pkg::BYTE_W-1:0] res_mem   [rfc_pkg::MAX_LEN];

    logic                         direction_reg;
    logic [rfc_pkg::RAILS_W-1:0]  rails_reg;
    logic [rfc_pkg::LEN_W-1:0]    len_reg, len_next;
    logic                         ovf_reg, ovf_next;

    logic                         dir_reg, dir_next;
    logic                         ident_reg, ident_next;
    logic [rfc_pkg::RAILS_W-1:0]  km1_reg, km1_next;
    logic [rfc_pkg::SPAN_W-1:0]   period_reg, period_next;
    logic [rfc_pkg::ADDR_W-1:0]   lastidx_reg, lastidx_next;
    logic [rfc_pkg::ADDR_W-1:0]   i_reg, i_next;
    logic [rfc_pkg::RAILS_W-1:0]  r_reg, r_next;
    logic [rfc_pkg::LEN_W-1:0]    p_reg, p_next;
    logic                         phase_reg, phase_next;

    logic                         wr_pend_reg;
    logic [rfc_pkg::ADDR_W-1:0]   wr_addr_reg;
    logic [rfc_pkg::BYTE_W-1:0]   st_rd_data;
    logic [rfc_pkg::BYTE_W-1:0]   res_rd_data;

    logic [rfc_pkg::ADDR_W-1:0]   jrd_reg, jrd_next;
    logic [rfc_pkg::ADDR_W-1:0]   e_reg, e_next;

    logic                         out_valid_reg, out_valid_next;
    logic [rfc_pkg::BYTE_W-1:0]   out_byte_reg;
    logic                         out_last_reg;
    logic                         trunc_reg;

    logic                         accept;
    logic                         room;
    logic [rfc_pkg::ADDR_W-1:0]   st_rd_addr;
    logic [rfc_pkg::ADDR_W-1:0]   gen_wr_addr;
    logic [rfc_pkg::SPAN_W-1:0]   step_down, step_up, step_sel, step;
    logic [rfc_pkg::SUM_W-1:0]    cand;
    logic                         out_free;
    logic                         out_load;
    logic                         res_rd_en;
    logic [rfc_pkg::RAILS_W-1:0]  r_inc;

    assign in_stall = !ctrl.load_en;
    assign accept   = ctrl.load_en && in_valid;
    assign room     = (len_reg != rfc_pkg::LEN_W'(rfc_pkg::MAX_LEN));

    assign out_free  = !out_valid_reg || !out_stall;
    assign out_load  = ctrl.emit_en && out_free;
    assign res_rd_en = ctrl.emrd_en || out_load;

    assign st_rd_addr  = dir_reg ? i_reg : p_reg[rfc_pkg::ADDR_W-1:0];
    assign gen_wr_addr = dir_reg ? p_reg[rfc_pkg::ADDR_W-1:0] : i_reg;

    assign step_down = {km1_reg - r_reg, 1'b0};
    assign step_up   = {r_reg, 1'b0};
    assign step_sel  = phase_reg ? step_up : step_down;
    assign step      = (step_sel == '0) ? period_reg : step_sel;
    assign cand      = rfc_pkg::SUM_W'(p_reg) + rfc_pkg::SUM_W'(step);
    assign r_inc     = r_reg + 1'b1;

    assign stat.in_last_acc = accept && last_byte;
    assign stat.gen_end     = ctrl.perm_en && (i_reg == lastidx_reg);
    assign stat.emit_end    = out_load && (e_reg == lastidx_reg);

    always_comb
    begin
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        dir_next       = dir_reg;
        ident_next     = ident_reg;
        km1_next       = km1_reg;
        period_next    = period_reg;
        lastidx_next   = lastidx_reg;
        i_next         = i_reg;
        r_next         = r_reg;
        p_next         = p_reg;
        phase_next     = phase_reg;
        jrd_next       = jrd_reg;
        e_next         = e_reg;
        out_valid_next = out_valid_reg;

        if (accept)
        begin
            if (room)
            begin
                len_next = len_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end

        if (ctrl.setup_en)
        begin
            dir_next     = direction_reg;
            ident_next   = (rails_reg <= rfc_pkg::RAILS_W'(1));
            km1_next     = rails_reg - 1'b1;
            period_next  = {rails_reg - 1'b1, 1'b0};
            lastidx_next = rfc_pkg::ADDR_W'(len_reg - 1'b1);
            i_next       = '0;
            r_next       = '0;
            p_next       = '0;
            phase_next   = 1'b0;
            jrd_next     = '0;
            e_next       = '0;
        end

        if (ctrl.perm_en)
        begin
            i_next = i_reg + 1'b1;
            if (ident_reg)
            begin
                p_next = p_reg + 1'b1;
            end
            else if (cand < rfc_pkg::SUM_W'(len_reg))
            begin
                p_next     = rfc_pkg::LEN_W'(cand);
                phase_next = !phase_reg;
            end
            else
            begin
                r_next     = r_inc;
                p_next     = rfc_pkg::LEN_W'(r_inc);
                phase_next = 1'b0;
            end
        end

        if (res_rd_en)
        begin
            jrd_next = jrd_reg + 1'b1;
        end

        if (out_load)
        begin
            out_valid_next = 1'b1;
            e_next         = e_reg + 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (stat.emit_end)
        begin
            len_next = '0;
            ovf_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
            rails_reg     <= rfc_pkg::RAILS_RESET;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            dir_reg       <= 1'b0;
            ident_reg     <= 1'b0;
            km1_reg       <= '0;
            period_reg    <= '0;
            lastidx_reg   <= '0;
            i_reg         <= '0;
            r_reg         <= '0;
            p_reg         <= '0;
            phase_reg     <= 1'b0;
            wr_pend_reg   <= 1'b0;
            jrd_reg       <= '0;
            e_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                if (cfg_index == rfc_pkg::REG_DIRECTION)
                begin
                    direction_reg <= cfg_data[0];
                end
                else if (cfg_index == rfc_pkg::REG_RAILS)
                begin
                    rails_reg <= cfg_data;
                end
            end
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            dir_reg       <= dir_next;
            ident_reg     <= ident_next;
            km1_reg       <= km1_next;
            period_reg    <= period_next;
            lastidx_reg   <= lastidx_next;
            i_reg         <= i_next;
            r_reg         <= r_next;
            p_reg         <= p_next;
            phase_reg     <= phase_next;
            wr_pend_reg   <= ctrl.perm_en;
            jrd_reg       <= jrd_next;
            e_reg         <= e_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && room)
        begin
            store_mem[len_reg[rfc_pkg::ADDR_W-1:0]] <= data_byte;
        end
        if (ctrl.perm_en)
        begin
            st_rd_data <= store_mem[st_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.perm_en)
        begin
            wr_addr_reg <= gen_wr_addr;
        end
        if (wr_pend_reg)
        begin
            res_mem[wr_addr_reg] <= st_rd_data;
        end
        if (res_rd_en)
        begin
            res_rd_data <= res_mem[jrd_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_byte_reg <= res_rd_data;
            out_last_reg <= (e_reg == lastidx_reg);
            trunc_reg    <= ovf_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_last  = out_last_reg;
    assign truncated = trunc_reg;

endmodule

// ----- rtl/core/rail_fence_cipher.sv -----
// Rail fence cipher top level: items are loaded until the one marked last. After
// it come a setup step, then permutation through the zigzag address walker (one
// message store read per cycle), a drain step and a first result store read to
// settle the result store, then one result per cycle while the output is not
// stalled. Reset is asynchronous, clears control state and sets direction to encrypt
// and rails to two; the stores are not cleared.
module rail_fence_cipher (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [rfc_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [rfc_pkg::CFG_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [rfc_pkg::BYTE_W-1:0]   data_byte,
    input  logic                         last_byte,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [rfc_pkg::BYTE_W-1:0]   out_byte,
    output logic                         out_last,
    output logic                         truncated
);

    rfc_pkg::ctrl_t ctrl;
    rfc_pkg::stat_t stat;

    rfc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    rfc_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .stat      (stat),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .truncated (truncated)
    );

endmodule

// ----- rtl/core/rfc_checker.sv -----
// Rail fence cipher port checker and its bind to the top level.
// Depends on rfc_pkg and rail_fence_cipher.
module rfc_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         cfg_wr_en,
    input logic [rfc_pkg::CIDX_W-1:0]   cfg_index,
    input logic [rfc_pkg::CFG_W-1:0]    cfg_data,
    input logic                         in_valid,
    input logic                         in_stall,
    input logic [rfc_pkg::BYTE_W-1:0]   data_byte,
    input logic                         last_byte,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic [rfc_pkg::BYTE_W-1:0]   out_byte,
    input logic                         out_last,
    input logic                         truncated
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_byte)
            && $stable(out_last) && $stable(truncated))
        else $error("Stalled output item changed.");

    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |-> !out_valid)
        else $error("Output valid during reset.");

    a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_byte |=> in_stall)
        else $error("Input taken straight after the final item of a message.");

    a_trunc_steady: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !out_last |=> !out_valid || truncated == $past(truncated))
        else $error("Truncated flag changed within a message.");

endmodule

bind rail_fence_cipher rfc_checker u_rfc_checker (.*);

// ----- bench/rail_fence_cipher_tb.sv -----
// Self-checking testbench for the rail fence cipher block: directed and random messages,
// compared byte by byte with an in-bench zigzag predictor under random idling.
// Depends on rfc_pkg and rail_fence_cipher.
module rail_fence_cipher_tb;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;
    localparam int   PLAN_ROWS   = 24;
    localparam int   RANDOM_ITEMS = 350;

    typedef struct packed {
        logic [rfc_pkg::BYTE_W-1:0] val;
        logic                       fin;
        logic                       trunc;
    } cipher_byte_t;

    typedef struct packed {
        logic                        cfg;
        logic                        dir;
        logic [rfc_pkg::RAILS_W-1:0] rails;
        logic [rfc_pkg::BYTE_W-1:0]  data;
        logic                        fin;
        logic                        typed;
        logic [rfc_pkg::BYTE_W-1:0]  want;
        logic                        want_fin;
        logic                        want_trunc;
    } plan_row_t;

    typedef enum logic [1:0] {
        SINK_READY,
        SINK_RANDOM,
        SINK_TOGGLE
    } sink_mode_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_wr_en;
    logic [rfc_pkg::CIDX_W-1:0]   cfg_index;
    logic [rfc_pkg::CFG_W-1:0]    cfg_data;
    logic                         in_valid;
    logic                         in_stall;
    logic [rfc_pkg::BYTE_W-1:0]   data_byte;
    logic                         last_byte;
    logic                         out_valid;
    logic                         out_stall;
    logic [rfc_pkg::BYTE_W-1:0]   out_byte;
    logic                         out_last;
    logic                         truncated;

    cipher_byte_t                 due_bytes [$];
    int                           bad_bytes  = 0;
    int                           burst_left = 0;
    int                           hold_req   = 0;

    logic [rfc_pkg::BYTE_W-1:0]   msg_store [rfc_pkg::MAX_LEN];
    int                           msg_len    = 0;
    logic                         msg_over   = 1'b0;
    logic                         pred_dir   = DIR_ENCRYPT;
    logic [rfc_pkg::RAILS_W-1:0]  pred_rails = rfc_pkg::RAILS_RESET;
    logic [rfc_pkg::BYTE_W-1:0]   perm_bytes [rfc_pkg::MAX_LEN];
    logic                         perm_trunc;

    // Single-byte messages carry their expected result; the rest go through the predictor.
    plan_row_t plan [PLAN_ROWS] = '{
        '{1'b0, DIR_ENCRYPT, 7'd2,  8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b0},
        '{1'b0, DIR_ENCRYPT, 7'd2,  8'hFF, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, DIR_ENCRYPT, 7'd2,  8'h00, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, DIR_ENCRYPT, 7'd2,  8'h80, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, DIR_ENCRYPT, 7'd2,  8'h01, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b1, DIR_ENCRYPT, 7'd3,  8'h55, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, DIR_ENCRYPT, 7'd3,  8'hAA, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, DIR_ENCRYPT, 7'd3,  8'h0F, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, DIR_ENCRYPT, 7'd3,  8'hF0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, DIR_ENCRYPT, 7'd3,  8'h7E, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b1, DIR_DECRYPT, 7'd3,  8'h55, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, DIR_DECRYPT, 7'd3,  8'hAA, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, DIR_DECRYPT, 7'd3,  8'h0F, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, DIR_DECRYPT, 7'd3,  8'hF0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, DIR_DECRYPT, 7'd3,  8'h7E, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b1, DIR_ENCRYPT, 7'd1,  8'h12, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, DIR_ENCRYPT, 7'd1,  8'h34, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, DIR_ENCRYPT, 7'd1,  8'h56, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b1, DIR_DECRYPT, 7'd0,  8'hC3, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, DIR_DECRYPT, 7'd0,  8'h3C, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b1, DIR_ENCRYPT, 7'd64, 8'h01, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, DIR_ENCRYPT, 7'd64, 8'h02, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, DIR_ENCRYPT, 7'd64, 8'h03, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0},
        '{1'b0, DIR_ENCRYPT, 7'd64, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 1'b0}
    };

    rail_fence_cipher u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_byte  (out_byte),
        .out_last  (out_last),
        .truncated (truncated)
    );

    // Stores one byte and, on the final byte, fills perm_bytes with the permuted message.
    function automatic int rail_fence_step(input logic [rfc_pkg::BYTE_W-1:0] b,
                                           input logic fin);
        int order [rfc_pkg::MAX_LEN];
        int n;
        int k;
        int cnt;
        int period;
        int m;
        int on_rail;
        int r;
        int p;
        int i;
        if (msg_len < rfc_pkg::MAX_LEN)
        begin
            msg_store[msg_len] = b;
            msg_len++;
        end
        else
        begin
            msg_over = 1'b1;
        end
        if (!fin)
        begin
            return 0;
        end
        n = msg_len;
        k = int'(pred_rails);
        cnt = 0;
        if (k <= 1)
        begin
            for (i = 0; i < n; i++)
            begin
                order[i] = i;
            end
            cnt = n;
        end
        else
        begin
            period = 2 * (k - 1);
            for (r = 0; r < k; r++)
            begin
                for (p = 0; p < n; p++)
                begin
                    m = p % period;
                    on_rail = (m < k) ? m : period - m;
                    if (on_rail == r && cnt < rfc_pkg::MAX_LEN)
                    begin
                        order[cnt] = p;
                        cnt++;
                    end
                end
            end
        end
        for (i = 0; i < cnt; i++)
        begin
            if (pred_dir == DIR_ENCRYPT)
            begin
                perm_bytes[i] = msg_store[order[i]];
            end
            else
            begin
                perm_bytes[order[i]] = msg_store[i];
            end
        end
        perm_trunc = msg_over;
        msg_len = 0;
        msg_over = 1'b0;
        return n;
    endfunction

    task automatic send_byte(input logic [rfc_pkg::BYTE_W-1:0] b, input logic fin,
                             input logic typed, input cipher_byte_t typed_want);
        int n;
        int i;
        cipher_byte_t due_item;
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 40);
        end
        else
        begin
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= fin;
        do @(posedge clk); while (in_stall);
        burst_left--;
        n = rail_fence_step(b, fin);
        if (typed)
        begin
            due_bytes.insert(due_bytes.size(), typed_want);
        end
        else
        begin
            for (i = 0; i < n; i++)
            begin
                due_item.val   = perm_bytes[i];
                due_item.fin   = (i == n - 1);
                due_item.trunc = perm_trunc;
                due_bytes.insert(due_bytes.size(), due_item);
            end
        end
    endtask

    // Registers are only written once the block has drained and sat idle for a while.
    task automatic program_cipher(input logic dir, input logic [rfc_pkg::RAILS_W-1:0] rails);
        @(negedge clk);
        in_valid <= 1'b0;
        while (due_bytes.size() != 0) @(posedge clk);
        repeat (8) @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= rfc_pkg::REG_DIRECTION;
        cfg_data  <= rfc_pkg::CFG_W'(dir);
        @(negedge clk);
        cfg_index <= rfc_pkg::REG_RAILS;
        cfg_data  <= rails;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
        pred_dir   = dir;
        pred_rails = rails;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2000000;
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int hold_left;
        int mode_left;
        sink_mode_t mode;
        hold_left = 0;
        mode_left = 0;
        mode = SINK_READY;
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req != 0)
            begin
                hold_left = hold_req;
                hold_req = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = sink_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(40, 200);
                end
                mode_left--;
                case (mode)
                    SINK_READY:  out_stall <= 1'b0;
                    SINK_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
                    default:     out_stall <= ~out_stall;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cipher_byte_t got;
        cipher_byte_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{out_byte, out_last, truncated};
            if (due_bytes.size() == 0)
            begin
                bad_bytes++;
                if (bad_bytes <= 10)
                begin
                    $display("Unexpected item: byte %h last %b truncated %b",
                             got.val, got.fin, got.trunc);
                end
            end
            else
            begin
                want = due_bytes.pop_front();
                if (got !== want)
                begin
                    bad_bytes++;
                    if (bad_bytes <= 10)
                    begin
                        $display({"Mismatch: expected byte %h last %b truncated %b, ",
                                  "got byte %h last %b truncated %b"},
                                 want.val, want.fin, want.trunc,
                                 got.val, got.fin, got.trunc);
                    end
                end
            end
        end
    end

    initial
    begin
        int r;
        int msg_idx;
        int items_sent;
        int len;
        int i;
        logic [rfc_pkg::RAILS_W-1:0] rails;
        rst_n     = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        data_byte = '0;
        last_byte = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (r = 0; r < PLAN_ROWS; r++)
        begin
            if (plan[r].cfg)
            begin
                program_cipher(plan[r].dir, plan[r].rails);
            end
            send_byte(plan[r].data, plan[r].fin, plan[r].typed,
                      '{plan[r].want, plan[r].want_fin, plan[r].want_trunc});
        end

        msg_idx = 0;
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (msg_idx % 6 == 0)
            begin
                case ($urandom_range(0, 9))
                    0:       rails = 7'd1;
                    1:       rails = 7'd64;
                    2:       rails = 7'd0;
                    3:       rails = 7'd127;
                    4:       rails = 7'd2;
                    default: rails = rfc_pkg::RAILS_W'($urandom_range(2, 63));
                endcase
                program_cipher(logic'($urandom_range(0, 1)), rails);
            end
            if (msg_idx == 2)
            begin
                len = rfc_pkg::MAX_LEN;
            end
            else if (msg_idx == 5)
            begin
                len = rfc_pkg::MAX_LEN + 1;
            end
            else if (msg_idx == 9)
            begin
                len = rfc_pkg::MAX_LEN + 6;
            end
            else if ($urandom_range(0, 15) == 0)
            begin
                len = $urandom_range(40, rfc_pkg::MAX_LEN + 8);
            end
            else
            begin
                len = $urandom_range(1, 12);
            end
            for (i = 0; i < len; i++)
            begin
                send_byte(rfc_pkg::BYTE_W'($urandom_range(0, 255)), i == len - 1, 1'b0, '0);
            end
            items_sent += len;
            // Hold the output back while the sender keeps offering, so the block backs up.
            if (msg_idx == 10)
            begin
                hold_req = 300;
            end
            msg_idx++;
        end

        @(negedge clk);
        in_valid <= 1'b0;
        while (due_bytes.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (bad_bytes == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
